// ===== src/rgbadp_pkg.sv =====
// Shared types and constants for the RGBA to display page byte packer.
package rgbadp_pkg;

  localparam int PAGE_ROWS = 8;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_NO_COMPLEMENT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] column_byte;
    logic [6:0] column_index;
    logic [2:0] page_index;
    logic       frame_last;
  } result_t;

  // Per-pixel decision handed from the scan counters to the update stage.
  typedef struct packed {
    logic [2:0] row_in_page;
    logic       pix_bit;
    logic       emit;
    logic [6:0] column_index;
    logic [2:0] page_index;
    logic       frame_last;
  } scan_t;

endpackage

// ===== src/rgbadp_scan.sv =====
// Configuration registers and raster counters that place each pixel.
module rgbadp_scan #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64,
  parameter int CW         = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [7:0]            cfg_data,
  input  logic                  accept,
  input  rgbadp_pkg::pixel_t    pix,
  output logic [CW-1:0]         col_addr,
  output rgbadp_pkg::scan_t     info,
  output logic                  no_complement
);
  import rgbadp_pkg::*;

  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = ((WW > HW) ? ((WW > 8) ? WW : 8) : ((HW > 8) ? HW : 8)) + 1;

  logic [7:0]    image_width_r;
  logic [6:0]    image_height_r;
  logic          no_comp_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [CW-1:0]   cc;
  logic [RW-1:0]   rc;
  logic [RW+2:0]   rc_x;
  logic [CMPW-1:0] w_c, h_c;
  logic            last_col, last_row;
  logic [2:0]      k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 8'd32;
      image_height_r <= 7'd32;
      no_comp_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH:   image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:  image_height_r <= cfg_data[6:0];
        CFG_NO_COMPLEMENT: no_comp_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate the configured size to 1..MAX.
  always_comb begin
    if (image_width_r == 8'd0)
      w_c = CMPW'(1);
    else if (CMPW'(image_width_r) > CMPW'(MAX_WIDTH))
      w_c = CMPW'(MAX_WIDTH);
    else
      w_c = CMPW'(image_width_r);
    if (image_height_r == 7'd0)
      h_c = CMPW'(1);
    else if (CMPW'(image_height_r) > CMPW'(MAX_HEIGHT))
      h_c = CMPW'(MAX_HEIGHT);
    else
      h_c = CMPW'(image_height_r);
  end

  assign cc       = pix.frame_start ? '0 : col_r;
  assign rc       = pix.frame_start ? '0 : row_r;
  assign rc_x     = (RW+3)'(rc);
  assign k        = rc_x[2:0];
  assign last_col = (CMPW'(cc) + CMPW'(1)) >= w_c;
  assign last_row = (CMPW'(rc) + CMPW'(1)) >= h_c;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : RW'(rc + RW'(1));
      end else begin
        col_nxt = CW'(cc + CW'(1));
        row_nxt = rc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col_addr          = cc;
  assign info.row_in_page  = k;
  assign info.pix_bit      = (pix.alpha != 8'd0) &&
                             ((pix.red != 8'd0) || (pix.green != 8'd0) || (pix.blue != 8'd0));
  assign info.emit         = (k == 3'(PAGE_ROWS - 1)) || last_row;
  assign info.column_index = 7'(cc);
  assign info.page_index   = 3'(rc_x >> 3);
  assign info.frame_last   = last_row && last_col;
  assign no_complement     = no_comp_r;

endmodule

// ===== src/rgbadp_store.sv =====
// Column byte store: one write port, one registered read port.
module rgbadp_store #(
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/rgba_to_display_page_bytes_core.sv =====
// Top level: packs RGBA pixels into monochrome display page column bytes.
// A pixel's result goes through the update stage register, then the output register.
// Throughput: one pixel per cycle unless an output stall holds the update stage;
// each pixel does one store read-modify-write (registered read, bypassed write).
// Reset (rst_n low, synchronous): counters clear, registers return to width 32,
// height 32, complement on; the column store is not cleared.
module rgba_to_display_page_bytes_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbadp_pkg::pixel_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbadp_pkg::result_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [7:0]           cfg_data
);
  import rgbadp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic          in_xfer;
  logic [CW-1:0] scan_addr;
  scan_t         scan_info;
  logic          no_comp;

  // Update stage: holds the pixel whose column byte is being read.
  logic          s1_v_r, s1_v_nxt;
  scan_t         s1_info_r;
  logic [CW-1:0] s1_addr_r;
  logic          s1_byp_r;
  logic [7:0]    s1_bypd_r;
  logic          s1_adv;

  logic [7:0] rd_data;
  logic [7:0] base;
  logic [7:0] packed_byte;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;
  logic    out_free;

  rgbadp_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .accept        (in_xfer),
    .pix           (in_data),
    .col_addr      (scan_addr),
    .info          (scan_info),
    .no_complement (no_comp)
  );

  rgbadp_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_store (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (scan_addr),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (packed_byte)
  );

  // The output register is free when empty or when its transfer completes now.
  assign out_free = !out_valid_r || !out_stall;
  // Advance the update stage unless its result would overwrite a held one.
  assign s1_adv   = s1_v_r && (!s1_info_r.emit || out_free);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  // A write-back to the column just read at the same edge left stale read
  // data; take the written byte instead. The first row of a page starts at zero.
  assign base        = s1_byp_r ? s1_bypd_r : rd_data;
  assign packed_byte = ((s1_info_r.row_in_page == 3'd0) ? 8'd0 : base) |
                       (8'(s1_info_r.pix_bit) << s1_info_r.row_in_page);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer)
      s1_v_nxt = 1'b1;
    else if (s1_adv)
      s1_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_info_r <= scan_info;
      s1_addr_r <= scan_addr;
      s1_byp_r  <= s1_adv && (s1_addr_r == scan_addr);
      s1_bypd_r <= packed_byte;
    end
  end

  // Output register: load on an emitting advance, drop after its transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_info_r.emit)
      out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_info_r.emit) begin
      out_data_r.column_byte  <= no_comp ? packed_byte : ~packed_byte;
      out_data_r.column_index <= s1_info_r.column_index;
      out_data_r.page_index   <= s1_info_r.page_index;
      out_data_r.frame_last   <= s1_info_r.frame_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/page_byte_checker.sv =====
// Scoreboard for the page packer: watches both channels, predicts and compares column bytes.
module page_byte_checker #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  rgbadp_pkg::pixel_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rgbadp_pkg::result_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [7:0]          cfg_data,
  output int                  fail_count,
  output int                  bytes_waiting,
  output int                  bytes_checked
);
  import rgbadp_pkg::*;

  logic [7:0]  width_reg;
  logic [6:0]  height_reg;
  logic        no_complement_reg;
  logic [7:0]  column_bytes [MAX_WIDTH];
  int unsigned col_pos;
  int unsigned row_pos;
  result_t     expected_bytes [$];
  int          errors = 0;
  int          checked = 0;

  initial begin
    foreach (column_bytes[i]) column_bytes[i] = 8'h00;
  end

  // Fold one pixel into its column byte; queue the byte when the page row closes it.
  task automatic pack_pixel(input pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned k;
    int unsigned slot;
    logic [7:0]  col_byte;
    logic        lit;
    logic        last_row;
    logic        last_col;
    result_t     r;
    if (width_reg == 8'd0) w = 1;
    else if (int'(width_reg) > MAX_WIDTH) w = MAX_WIDTH;
    else w = int'(width_reg);
    if (height_reg == 7'd0) h = 1;
    else if (int'(height_reg) > MAX_HEIGHT) h = MAX_HEIGHT;
    else h = int'(height_reg);
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    lit = (px.alpha != 8'd0) && ((px.red | px.green | px.blue) != 8'd0);
    k = row_pos % PAGE_ROWS;
    slot = col_pos % MAX_WIDTH;
    col_byte = (k == 0) ? 8'h00 : column_bytes[slot];
    col_byte[k] = col_byte[k] | lit;
    column_bytes[slot] = col_byte;
    last_row = (row_pos + 1 >= h);
    last_col = (col_pos + 1 >= w);
    if (k == PAGE_ROWS - 1 || last_row) begin
      r.column_byte  = no_complement_reg ? col_byte : ~col_byte;
      r.column_index = col_pos[6:0];
      r.page_index   = 3'(row_pos / PAGE_ROWS);
      r.frame_last   = last_row && last_col;
      expected_bytes.push_back(r);
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_byte(input result_t got);
    result_t want;
    if (expected_bytes.size() == 0) begin
      $error("column byte %0h at column %0d page %0d arrived with none expected",
             got.column_byte, got.column_index, got.page_index);
      errors++;
    end else begin
      want = expected_bytes.pop_front();
      checked++;
      if (got.column_byte !== want.column_byte) begin
        $error("column_byte: expected %0h, got %0h", want.column_byte, got.column_byte);
        errors++;
      end
      if (got.column_index !== want.column_index) begin
        $error("column_index: expected %0d, got %0d", want.column_index, got.column_index);
        errors++;
      end
      if (got.page_index !== want.page_index) begin
        $error("page_index: expected %0d, got %0d", want.page_index, got.page_index);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = 8'd32;
      height_reg = 7'd32;
      no_complement_reg = 1'b0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          CFG_IMAGE_WIDTH:   width_reg = cfg_data;
          CFG_IMAGE_HEIGHT:  height_reg = cfg_data[6:0];
          CFG_NO_COMPLEMENT: no_complement_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_byte(out_data);
      if (in_valid && !in_stall) pack_pixel(in_data);
    end
    fail_count    <= errors;
    bytes_waiting <= expected_bytes.size();
    bytes_checked <= checked;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Regression top for the page packer: clock, reset, pixel stimulus, settings and verdict.
module testbench;
  import rgbadp_pkg::*;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 64;
  // Wait a little past the drain so a pixel that closes no page has surely left
  // the pipe before the registers change.
  localparam int SETTLE = 4;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  pixel_t     in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  result_t    out_data;
  logic       cfg_we;
  logic [1:0] cfg_addr;
  logic [7:0] cfg_data;

  int          fail_count;
  int          bytes_waiting;
  int          bytes_checked;
  logic        calm;          // high: no gaps from the sender, no stalls from the sink
  int          stall_left = 0;
  int unsigned image_w;
  int unsigned image_h;
  int unsigned image_pos;     // pixel position inside the current image, stimulus side
  int          pixels_sent = 0;
  int          settings_run = 0;

  // Fixed colors for the directed part: {red, green, blue, alpha}.
  logic [31:0] swatch [6] = '{32'hFFFFFFFF, 32'h000000FF, 32'hFFFFFF00,
                              32'h01000001, 32'h00800080, 32'h0000FF7F};

  rgba_to_display_page_bytes_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  page_byte_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) byte_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .bytes_waiting(bytes_waiting),
    .bytes_checked(bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a transfer for good.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // Sink backpressure: random stall bursts, with open stretches between.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 15) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end
  end

  // Write one register; returns on the edge that takes the write.
  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Program all three registers and track the image size the block will clamp to.
  task automatic apply_setting(input logic [7:0] w, input logic [6:0] h, input logic nc);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, {1'b0, h});
    write_reg(CFG_NO_COMPLEMENT, {7'd0, nc});
    cfg_we <= 1'b0;
    if (w == 8'd0) image_w = 1;
    else if (int'(w) > MAX_WIDTH) image_w = MAX_WIDTH;
    else image_w = int'(w);
    if (h == 7'd0) image_h = 1;
    else if (int'(h) > MAX_HEIGHT) image_h = MAX_HEIGHT;
    else image_h = int'(h);
    image_pos = 0;
    settings_run++;
  endtask

  // Mostly small images, now and then any value the register holds (clamped by the block).
  task automatic random_setting();
    logic [7:0] w;
    logic [6:0] h;
    w = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 12)) : 8'($urandom_range(0, 255));
    h = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 20)) : 7'($urandom_range(0, 127));
    apply_setting(w, h, 1'($urandom_range(0, 1)));
  endtask

  // Present one pixel and hold it until the block takes it. Sample stall at the
  // falling edge so the decision never races the block's own update.
  task automatic send_pixel(input pixel_t px);
    logic taken;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pixels_sent++;
  endtask

  // Random color, biased so each way of going dark and each lone channel shows up often.
  function automatic pixel_t random_pixel(input logic fs);
    pixel_t px;
    px.red   = 8'($urandom_range(0, 255));
    px.green = 8'($urandom_range(0, 255));
    px.blue  = 8'($urandom_range(0, 255));
    px.alpha = 8'($urandom_range(0, 255));
    px.frame_start = fs;
    case ($urandom_range(0, 7))
      0: px.alpha = 8'h00;
      1: {px.red, px.green, px.blue} = '0;
      2: {px.green, px.blue} = '0;
      3: {px.red, px.blue} = '0;
      4: {px.red, px.green} = '0;
      default: ;
    endcase
    return px;
  endfunction

  // Stream whole images: frame start on most image boundaries, the rest wrap on their
  // own; with noise, an occasional frame start lands mid-image.
  task automatic run_images(input int count, input int start_pct, input bit noise);
    logic fs;
    for (int n = 0; n < count; n++) begin
      fs = (image_pos == 0 && $urandom_range(0, 99) < start_pct) ||
           (noise && $urandom_range(0, 99) < 3);
      if (fs) image_pos = 0;
      send_pixel(random_pixel(fs));
      image_pos = (image_pos + 1) % (image_w * image_h);
    end
  endtask

  // Drop valid, wait for every queued byte, then let the pipe settle.
  task automatic drain();
    int spins;
    spins = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      spins++;
    end while (bytes_waiting != 0 && spins < 5000);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_addr <= CFG_IMAGE_WIDTH;
    cfg_data <= 8'd0;
    calm     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Full-width single-row image first: every column entry gets written on a
    // page's first row before anything can read it back.
    apply_setting(8'd128, 7'd1, 1'b1);
    run_images(MAX_WIDTH, 100, 1'b0);
    drain();

    // Directed: 2 x 9 image, so one full page plus a one-row partial page, emitted
    // complemented. Two pixels past the end wrap into a new image, then a frame
    // start restarts it; the swatches walk through white, black, clear, lone channels.
    apply_setting(8'd2, 7'd9, 1'b0);
    for (int i = 0; i < 22; i++) begin
      send_pixel({swatch[i % 6], (i == 0 || i == 20)});
    end
    drain();

    // Register extremes: zero width and height clamp to one pixel, so each pixel is
    // a whole image; top values clamp to the maximum; a one-column image walks all pages.
    apply_setting(8'd0, 7'd0, 1'b1);
    run_images(60, 70, 1'b1);
    drain();
    apply_setting(8'd255, 7'd127, 1'b0);
    run_images(200, 70, 1'b1);
    drain();
    apply_setting(8'd1, 7'd127, 1'b1);
    run_images(140, 70, 1'b1);
    drain();

    // Random settings; a phase may open mid-image, so the counters meet new bounds.
    for (int s = 0; s < 10; s++) begin
      calm <= (s % 4 == 3);
      random_setting();
      run_images(125, 70, 1'b1);
      drain();
    end

    // Closing stretch with both sides streaming flat out.
    calm <= 1'b1;
    random_setting();
    run_images(150, 70, 1'b1);
    drain();

    if (bytes_waiting != 0) $error("%0d expected column bytes never arrived", bytes_waiting);
    $display("Streamed %0d pixels under %0d register settings; %0d column bytes compared",
             pixels_sent, settings_run, bytes_checked);
    if (fail_count == 0 && bytes_waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
